// ===== rtl/srh_pkg.sv =====
package srh_pkg;

  localparam int HW = 61;
  localparam logic [HW-1:0] HMOD = {HW{1'b1}};
  localparam logic [HW-1:0] BASE_RESET = 61'd414123123;
  localparam int MAX_LEN_DEF = 4096;
  localparam int FW = 13;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_SUB    = 3'd2;
  localparam logic [2:0] CMD_LCP    = 3'd3;
  localparam logic [2:0] CMD_UNITE  = 3'd4;

  localparam logic [4:0] OP_NONE  = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_FINIT = 5'd2;
  localparam logic [4:0] OP_FMUL  = 5'd3;
  localparam logic [4:0] OP_FWR   = 5'd4;
  localparam logic [4:0] OP_ARD   = 5'd5;
  localparam logic [4:0] OP_AMUL  = 5'd6;
  localparam logic [4:0] OP_AWR   = 5'd7;
  localparam logic [4:0] OP_SRD   = 5'd8;
  localparam logic [4:0] OP_SMUL  = 5'd9;
  localparam logic [4:0] OP_SHLD  = 5'd10;
  localparam logic [4:0] OP_SFIN  = 5'd11;
  localparam logic [4:0] OP_LINIT = 5'd12;
  localparam logic [4:0] OP_LHLD  = 5'd13;
  localparam logic [4:0] OP_LRD   = 5'd14;
  localparam logic [4:0] OP_LMUL  = 5'd15;
  localparam logic [4:0] OP_LGET  = 5'd16;
  localparam logic [4:0] OP_LCMP  = 5'd17;
  localparam logic [4:0] OP_LDONE = 5'd18;
  localparam logic [4:0] OP_URD   = 5'd19;
  localparam logic [4:0] OP_UMUL  = 5'd20;
  localparam logic [4:0] OP_UFIN  = 5'd21;
  localparam logic [4:0] OP_ERR   = 5'd22;
  localparam logic [4:0] OP_EMIT  = 5'd23;

  typedef struct packed {
    logic [4:0] op;
  } srh_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       app_full;
    logic       sub_bad;
    logic       lcp_bad;
    logic       uni_bad;
    logic       lcp_more;
    logic       fill_last;
    logic       mul_done;
    logic       out_free;
  } srh_sts_t;

  // x < 2^63 -> canonical residue mod 2^61-1
  function automatic logic [HW-1:0] fold61(input logic [HW+1:0] x);
    logic [HW:0] t;
    begin
      t = {1'b0, x[HW-1:0]} + {{(HW-1){1'b0}}, x[HW+1:HW]};
      if (t >= {1'b0, HMOD}) begin
        t = t - {1'b0, HMOD};
      end
      fold61 = t[HW-1:0];
    end
  endfunction

endpackage

// ===== rtl/substring_rolling_hash_engine.sv =====
// channel  | signals                                   | beat moves
// in       | in_tvalid/in_tready/in_tdata/in_tuser     | one command
// out      | out_tvalid/out_tready/out_tdata/out_tuser | one result per command
// cfg      | cfg_psel/penable/pwrite/paddr/pwdata/...  | base register at address 0
// one command at a time; all modular products go through one iterative unit
// (four 31x31 partial products, then a fold of their sum and a final fold61)
// lcp runs a binary search of about log2(len-left+1) probes;
// clear refills the power table
// after reset the same power refill runs before the first beat is taken
// a result waiting in the output register blocks only the next result
module substring_rolling_hash_engine #(
  parameter int MAX_LEN = srh_pkg::MAX_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // symbol[7:0], left[20:8], right[33:21], hash_a[94:34], hash_b[155:95], shift[168:156]
  input  logic [175:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hash_value[60:0], lcp_length[73:61], stored_length[86:74]
  output logic [87:0]  out_tdata,
  // error[0]
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import srh_pkg::*;

  srh_ctl_t      ctl;
  srh_sts_t      sts;
  logic          cfg_we;
  logic [HW-1:0] base_value;
  logic [HW-1:0] hv;
  logic [12:0]   lcp_len, st_len;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 4'd0);
  assign cfg_prdata = (cfg_paddr == 4'd0) ? {3'd0, base_value} : 64'd0;

  srh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  srh_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .cmd               (in_tuser),
    .symbol            (in_tdata[7:0]),
    .left              (in_tdata[20:8]),
    .right             (in_tdata[33:21]),
    .hash_a            (in_tdata[94:34]),
    .hash_b            (in_tdata[155:95]),
    .shift             (in_tdata[168:156]),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_pwdata[HW-1:0]),
    .base_value        (base_value),
    .out_ready         (out_tready),
    .out_valid         (out_tvalid),
    .out_hash_value    (hv),
    .out_lcp_length    (lcp_len),
    .out_stored_length (st_len),
    .out_error         (out_tuser)
  );

  assign out_tdata = {1'b0, st_len, lcp_len, hv};
endmodule

// ===== rtl/srh_mulmod.sv =====
module srh_mulmod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [srh_pkg::HW-1:0] a,
  input  logic [srh_pkg::HW-1:0] b,
  output logic                  done,
  output logic [srh_pkg::HW-1:0] res
);
  import srh_pkg::*;

  logic [HW-1:0]   a_r, b_r;
  logic [2*HW-1:0] acc_r;
  logic [HW:0]     s_r;
  logic [2:0]      st_r;
  logic            busy_r, done_r;
  logic [HW-1:0]   res_r;
  logic [30:0]     x, y;
  logic [61:0]     pp;
  logic [2*HW-1:0] addend;

  // one 31x31 partial product per cycle
  always_comb begin
    x = st_r[0] ? {1'b0, a_r[60:31]} : a_r[30:0];
    y = st_r[1] ? {1'b0, b_r[60:31]} : b_r[30:0];
    pp = {31'd0, x} * {31'd0, y};
    case (st_r[1:0])
      2'd0:    addend = {60'd0, pp};
      2'd3:    addend = {pp[59:0], 62'd0};
      default: addend = {29'd0, pp, 31'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      st_r   <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        st_r   <= 3'd0;
      end else if (busy_r) begin
        st_r <= st_r + 3'd1;
        if (st_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (st_r < 3'd4) begin
        acc_r <= acc_r + addend;
      end else if (st_r == 3'd4) begin
        s_r <= {1'b0, acc_r[HW-1:0]} + {1'b0, acc_r[2*HW-1:HW]};
      end else begin
        res_r <= fold61({1'b0, s_r});
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

// ===== rtl/srh_dp.sv =====
module srh_dp #(
  parameter int MAX_LEN = srh_pkg::MAX_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  srh_pkg::srh_ctl_t      ctl,
  output srh_pkg::srh_sts_t      sts,
  input  logic [2:0]             cmd,
  input  logic [7:0]             symbol,
  input  logic [12:0]            left,
  input  logic [12:0]            right,
  input  logic [srh_pkg::HW-1:0] hash_a,
  input  logic [srh_pkg::HW-1:0] hash_b,
  input  logic [12:0]            shift,
  input  logic                   cfg_we,
  input  logic [srh_pkg::HW-1:0] cfg_wdata,
  output logic [srh_pkg::HW-1:0] base_value,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [srh_pkg::HW-1:0] out_hash_value,
  output logic [12:0]            out_lcp_length,
  output logic [12:0]            out_stored_length,
  output logic                   out_error
);
  import srh_pkg::*;

  localparam int AW = $clog2(MAX_LEN + 1);
  localparam int LW = AW + 1;
  localparam int CW = (LW > FW) ? LW : FW;

  logic [HW-1:0] pre_mem [0:MAX_LEN];
  logic [HW-1:0] pow_mem [0:MAX_LEN];

  logic [HW-1:0] base_r, b_r, pw_r, pre_rd_r, pow_rd_r, h_r, g_r, pa_r, hv_r;
  logic [HW-1:0] ha_r, hb_r;
  logic [2:0]    cmd_r;
  logic [7:0]    sym_r;
  logic [12:0]   left_r, right_r, k_r;
  logic [AW-1:0] len_r, cnt_r;
  logic [LW-1:0] lo_r, hi_r, mid_r, lcp_r;
  logic          err_r;
  logic          out_valid_r;
  logic [HW-1:0] out_hv_r;
  logic [12:0]   out_lcp_r, out_len_r;
  logic          out_err_r;

  logic [CW-1:0] left_c, right_c, k_c, len_c, diff_c;
  logic [AW-1:0] left_a, right_a, k_a, diff_a;
  logic [LW:0]   mid_sum;
  logic [LW-1:0] mid;
  logic [AW-1:0] pre_ra, pow_ra;
  logic          mul_start;
  logic [HW-1:0] mul_a, mul_b, mul_res;
  logic          mul_done;
  logic [HW-1:0] sym_c, sub_v;

  assign left_c  = CW'(left_r);
  assign right_c = CW'(right_r);
  assign k_c     = CW'(k_r);
  assign len_c   = CW'(len_r);
  assign diff_c  = right_c - left_c;
  assign left_a  = left_c[AW-1:0];
  assign right_a = right_c[AW-1:0];
  assign k_a     = k_c[AW-1:0];
  assign diff_a  = diff_c[AW-1:0];
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[LW:1];

  // byte maps to (byte - 96) mod p
  assign sym_c = (sym_r >= 8'd96) ? {53'd0, sym_r - 8'd96} : HMOD - {53'd0, 8'd96 - sym_r};
  assign sub_v = fold61({2'b0, h_r} + {2'b0, HMOD} - {2'b0, mul_res});

  always_comb begin
    sts.cmd       = cmd_r;
    sts.app_full  = (len_r == AW'(MAX_LEN));
    sts.sub_bad   = (left_c > right_c) || (right_c > len_c);
    sts.lcp_bad   = (left_c > len_c);
    sts.uni_bad   = (k_c > CW'(MAX_LEN));
    sts.lcp_more  = ((hi_r - lo_r) > LW'(1));
    sts.fill_last = (cnt_r == AW'(MAX_LEN - 1));
    sts.mul_done  = mul_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    pre_ra    = '0;
    pow_ra    = '0;
    mul_start = 1'b0;
    mul_a     = pre_rd_r;
    mul_b     = pow_rd_r;
    case (ctl.op)
      OP_FMUL: begin
        mul_start = 1'b1;
        mul_a     = pw_r;
        mul_b     = b_r;
      end
      OP_ARD: pre_ra = len_r;
      OP_AMUL: begin
        mul_start = 1'b1;
        mul_b     = b_r;
      end
      OP_SRD: begin
        pre_ra = left_a;
        pow_ra = diff_a;
      end
      OP_SMUL: begin
        mul_start = 1'b1;
        pre_ra    = right_a;
      end
      OP_LINIT: pre_ra = left_a;
      OP_LRD: begin
        pre_ra = left_a + mid[AW-1:0];
        pow_ra = mid[AW-1:0];
      end
      OP_LMUL: begin
        mul_start = 1'b1;
        mul_a     = pa_r;
        pre_ra    = mid_r[AW-1:0];
      end
      OP_URD: pow_ra = k_a;
      OP_UMUL: begin
        mul_start = 1'b1;
        mul_a     = ha_r;
      end
      default: begin
        pre_ra = '0;
      end
    endcase
  end

  srh_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    pre_rd_r <= pre_mem[pre_ra];
    pow_rd_r <= pow_mem[pow_ra];
    if (ctl.op == OP_FINIT) begin
      pre_mem[0] <= '0;
      pow_mem[0] <= {{(HW-1){1'b0}}, 1'b1};
    end else if (ctl.op == OP_FWR) begin
      pow_mem[cnt_r + AW'(1)] <= mul_res;
    end else if (ctl.op == OP_AWR) begin
      pre_mem[len_r + AW'(1)] <= fold61({2'b0, mul_res} + {2'b0, sym_c});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RESET;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (ctl.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.op)
        OP_LOAD:  err_r <= 1'b0;
        OP_ERR:   err_r <= 1'b1;
        OP_FINIT: begin
          len_r <= '0;
          cnt_r <= '0;
        end
        OP_FWR:   cnt_r <= cnt_r + AW'(1);
        OP_AWR:   len_r <= len_r + AW'(1);
        default:  err_r <= err_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_r   <= cmd;
        sym_r   <= symbol;
        left_r  <= left;
        right_r <= right;
        ha_r    <= hash_a;
        hb_r    <= hash_b;
        k_r     <= shift;
        hv_r    <= '0;
        lcp_r   <= '0;
      end
      OP_FINIT: begin
        pw_r <= {{(HW-1){1'b0}}, 1'b1};
        b_r  <= fold61({2'b0, base_r});
      end
      OP_FWR:   pw_r <= mul_res;
      OP_SHLD:  h_r <= pre_rd_r;
      OP_SFIN:  hv_r <= sub_v;
      OP_LINIT: begin
        lo_r <= '0;
        hi_r <= LW'(len_r) - LW'(left_a) + LW'(1);
      end
      OP_LHLD:  pa_r <= pre_rd_r;
      OP_LRD:   mid_r <= mid;
      OP_LMUL:  h_r <= pre_rd_r;
      OP_LGET:  g_r <= pre_rd_r;
      OP_LCMP: begin
        // prefix hash of length mid against the suffix window
        if (sub_v == g_r) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r;
        end
      end
      OP_LDONE: lcp_r <= lo_r;
      OP_UFIN:  hv_r <= fold61({2'b0, mul_res} + {2'b0, hb_r});
      OP_EMIT: begin
        out_hv_r  <= hv_r;
        out_lcp_r <= lcp_r[12:0];
        out_len_r <= len_c[12:0];
        out_err_r <= err_r;
      end
      default: begin
        pw_r <= pw_r;
      end
    endcase
  end

  assign base_value        = base_r;
  assign out_valid         = out_valid_r;
  assign out_hash_value    = out_hv_r;
  assign out_lcp_length    = out_lcp_r;
  assign out_stored_length = out_len_r;
  assign out_error         = out_err_r;
endmodule

// ===== rtl/srh_ctrl.sv =====
module srh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srh_pkg::srh_sts_t sts,
  output srh_pkg::srh_ctl_t ctl
);
  import srh_pkg::*;

  localparam logic [4:0] S_FINIT = 5'd0;
  localparam logic [4:0] S_FMUL  = 5'd1;
  localparam logic [4:0] S_FWAIT = 5'd2;
  localparam logic [4:0] S_IDLE  = 5'd3;
  localparam logic [4:0] S_DISP  = 5'd4;
  localparam logic [4:0] S_AMUL  = 5'd5;
  localparam logic [4:0] S_AWAIT = 5'd6;
  localparam logic [4:0] S_SMUL  = 5'd7;
  localparam logic [4:0] S_SHLD  = 5'd8;
  localparam logic [4:0] S_SWAIT = 5'd9;
  localparam logic [4:0] S_LHLD  = 5'd10;
  localparam logic [4:0] S_LCHK  = 5'd11;
  localparam logic [4:0] S_LMUL  = 5'd12;
  localparam logic [4:0] S_LGET  = 5'd13;
  localparam logic [4:0] S_LWAIT = 5'd14;
  localparam logic [4:0] S_UMUL  = 5'd15;
  localparam logic [4:0] S_UWAIT = 5'd16;
  localparam logic [4:0] S_EMIT  = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       emit_r, emit_nxt;

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    ctl.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_FINIT: begin
        ctl.op    = OP_FINIT;
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        ctl.op    = OP_FMUL;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (sts.mul_done) begin
          ctl.op = OP_FWR;
          if (!sts.fill_last) begin
            state_nxt = S_FMUL;
          end else if (emit_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_EMIT;
        case (sts.cmd)
          CMD_CLEAR: begin
            emit_nxt  = 1'b1;
            state_nxt = S_FINIT;
          end
          CMD_APPEND: begin
            if (sts.app_full) begin
              ctl.op = OP_ERR;
            end else begin
              ctl.op    = OP_ARD;
              state_nxt = S_AMUL;
            end
          end
          CMD_SUB: begin
            if (sts.sub_bad) begin
              ctl.op = OP_ERR;
            end else begin
              ctl.op    = OP_SRD;
              state_nxt = S_SMUL;
            end
          end
          CMD_LCP: begin
            if (sts.lcp_bad) begin
              ctl.op = OP_ERR;
            end else begin
              ctl.op    = OP_LINIT;
              state_nxt = S_LHLD;
            end
          end
          CMD_UNITE: begin
            if (sts.uni_bad) begin
              ctl.op = OP_ERR;
            end else begin
              ctl.op    = OP_URD;
              state_nxt = S_UMUL;
            end
          end
          default: ctl.op = OP_ERR;
        endcase
      end
      S_AMUL: begin
        ctl.op    = OP_AMUL;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (sts.mul_done) begin
          ctl.op    = OP_AWR;
          state_nxt = S_EMIT;
        end
      end
      S_SMUL: begin
        ctl.op    = OP_SMUL;
        state_nxt = S_SHLD;
      end
      S_SHLD: begin
        ctl.op    = OP_SHLD;
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.mul_done) begin
          ctl.op    = OP_SFIN;
          state_nxt = S_EMIT;
        end
      end
      S_LHLD: begin
        ctl.op    = OP_LHLD;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (sts.lcp_more) begin
          ctl.op    = OP_LRD;
          state_nxt = S_LMUL;
        end else begin
          ctl.op    = OP_LDONE;
          state_nxt = S_EMIT;
        end
      end
      S_LMUL: begin
        ctl.op    = OP_LMUL;
        state_nxt = S_LGET;
      end
      S_LGET: begin
        ctl.op    = OP_LGET;
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (sts.mul_done) begin
          ctl.op    = OP_LCMP;
          state_nxt = S_LCHK;
        end
      end
      S_UMUL: begin
        ctl.op    = OP_UMUL;
        state_nxt = S_UWAIT;
      end
      S_UWAIT: begin
        if (sts.mul_done) begin
          ctl.op    = OP_UFIN;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.op    = OP_EMIT;
          emit_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FINIT;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end
endmodule

// ===== tb/srh_checker.sv =====
`timescale 1ns / 1ps

module srh_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // symbol[7:0], left[20:8], right[33:21], hash_a[94:34], hash_b[155:95], shift[168:156]
  input  logic [175:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // hash_value[60:0], lcp_length[73:61], stored_length[86:74]
  input  logic [87:0]  out_tdata,
  // error[0]
  input  logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);
  import srh_pkg::*;

  localparam logic [3:0] ADDR_BASE = 4'd0;

  typedef struct packed {
    logic [HW-1:0] hv;
    logic [FW-1:0] lcp;
    logic [FW-1:0] len;
    logic          err;
  } hash_result_t;

  logic [HW-1:0] pow_tab [0:MAX_LEN_DEF];
  logic [HW-1:0] pre_tab [0:MAX_LEN_DEF];
  logic [HW-1:0] base_q;
  int            str_len;
  hash_result_t  results_due[$];
  hash_result_t  want, got;
  int            fails;

  function automatic logic [HW-1:0] reduce(input logic [HW+1:0] x);
    logic [HW:0] t;
    t = {1'b0, x[HW-1:0]} + {{(HW-1){1'b0}}, x[HW+1:HW]};
    if (t >= {1'b0, HMOD}) t = t - {1'b0, HMOD};
    return t[HW-1:0];
  endfunction

  function automatic logic [HW-1:0] mulmod(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [2*HW-1:0] p;
    p = {{HW{1'b0}}, a} * {{HW{1'b0}}, b};
    return reduce({2'b00, p[HW-1:0]} + {2'b00, p[2*HW-1:HW]});
  endfunction

  function logic [HW-1:0] range_hash(input int l, input int r);
    return reduce({2'b00, pre_tab[r]} + {2'b00, HMOD}
                  - {2'b00, mulmod(pre_tab[l], pow_tab[r-l])});
  endfunction

  function void refill_powers();
    logic [HW-1:0] b;
    b = reduce({2'b00, base_q});
    pow_tab[0] = HW'(1);
    for (int i = 1; i <= MAX_LEN_DEF; i++) pow_tab[i] = mulmod(pow_tab[i-1], b);
    pre_tab[0] = '0;
    str_len = 0;
  endfunction

  function hash_result_t apply_command(input logic [2:0] cmd, input logic [175:0] d);
    hash_result_t  res;
    logic [7:0]    sym;
    int            l, r, k, lo, hi, mid;
    logic [HW-1:0] ha, hb, c;
    sym = d[7:0];
    l   = int'(d[20:8]);
    r   = int'(d[33:21]);
    ha  = d[94:34];
    hb  = d[155:95];
    k   = int'(d[168:156]);
    res = '0;
    case (cmd)
      CMD_CLEAR: refill_powers();
      CMD_APPEND: begin
        if (str_len >= MAX_LEN_DEF) begin
          res.err = 1'b1;
        end else begin
          // bytes below 'a'-1 wrap to negative residues
          c = (sym >= 8'd96) ? HW'(sym - 8'd96) : HMOD - HW'(8'd96 - sym);
          pre_tab[str_len+1] = reduce({2'b00, mulmod(pre_tab[str_len], pow_tab[1])}
                                      + {2'b00, c});
          str_len++;
        end
      end
      CMD_SUB: begin
        if (l > r || r > str_len) res.err = 1'b1;
        else res.hv = range_hash(l, r);
      end
      CMD_LCP: begin
        if (l > str_len) begin
          res.err = 1'b1;
        end else begin
          lo = 0;
          hi = str_len - l + 1;
          while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (range_hash(0, mid) == range_hash(l, l + mid)) lo = mid;
            else hi = mid;
          end
          res.lcp = FW'(lo);
        end
      end
      CMD_UNITE: begin
        if (k > MAX_LEN_DEF) res.err = 1'b1;
        else res.hv = reduce({2'b00, mulmod(ha, pow_tab[k])} + {2'b00, hb});
      end
      default: res.err = 1'b1;
    endcase
    res.len = FW'(str_len);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      base_q = BASE_RESET;
      refill_powers();
      results_due.delete();
      fails = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_BASE)
        base_q = cfg_pwdata[HW-1:0];
      if (in_tvalid && in_tready)
        results_due.push_back(apply_command(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.hv  = out_tdata[60:0];
        got.lcp = out_tdata[73:61];
        got.len = out_tdata[86:74];
        got.err = out_tuser;
        if (results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $realtime, got);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (got.hv !== want.hv) begin
            $display("%0t: hash_value exp %h got %h", $realtime, want.hv, got.hv);
            fails++;
          end
          if (got.lcp !== want.lcp) begin
            $display("%0t: lcp_length exp %0d got %0d", $realtime, want.lcp, got.lcp);
            fails++;
          end
          if (got.len !== want.len) begin
            $display("%0t: stored_length exp %0d got %0d", $realtime, want.len, got.len);
            fails++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error exp %b got %b", $realtime, want.err, got.err);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= results_due.size();
  end

endmodule

// ===== tb/substring_rolling_hash_engine_tb.sv =====
`timescale 1ns / 1ps

module substring_rolling_hash_engine_tb;
  import srh_pkg::*;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam int         TOP = MAX_LEN_DEF;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;
  int           fail_count, pending;

  int           str_len;
  int           burst_left;
  int           cmd_seen[8];
  int           bases_used;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_cnt = 0;
  int           rx_mode = 0;
  int           rx_cyc = 0;
  int           period;
  logic [7:0]   pattern[0:15];

  always #4 clk = ~clk;

  substring_rolling_hash_engine uut (.*);

  srh_checker chk (.*);

  // receiver: a stall mode per window, plus one long hold-off on request
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 256 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_cnt   <= 400;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ~out_tready;
      endcase
    end
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [HW-1:0] rand61();
    return HW'({$urandom, $urandom});
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] sym, input int l,
                          input int r, input logic [HW-1:0] ha, input logic [HW-1:0] hb,
                          input int k);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, FW'(k), hb, ha, FW'(r), FW'(l), sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cmd_seen[cmd]++;
    if (cmd == CMD_CLEAR) str_len = 0;
    else if (cmd == CMD_APPEND && str_len < TOP) str_len++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [HW-1:0] v);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= '0;
    cfg_pwdata <= {3'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    bases_used++;
  endtask

  task automatic add_sym(input logic [7:0] s);
    send_cmd(CMD_APPEND, s, 0, 0, 0, 0, 0);
  endtask

  task automatic random_item();
    int pick, l, r;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 4) == 0) add_sym($urandom);
      else add_sym(pattern[str_len % period]);
    end else if (pick < 60) begin
      if ($urandom_range(0, 9) != 0 || str_len >= TOP) begin
        r = $urandom_range(0, str_len);
        l = $urandom_range(0, r);
      end else if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, str_len);
        l = $urandom_range(r + 1, TOP);
      end else begin
        r = $urandom_range(str_len + 1, TOP);
        l = $urandom_range(0, r);
      end
      send_cmd(CMD_SUB, $urandom, l, r, rand61(), rand61(), $urandom_range(0, TOP));
    end else if (pick < 80) begin
      if ($urandom_range(0, 9) != 0 || str_len >= TOP) l = $urandom_range(0, str_len);
      else l = $urandom_range(str_len + 1, TOP);
      send_cmd(CMD_LCP, $urandom, l, $urandom_range(0, TOP), rand61(), rand61(), 0);
    end else if (pick < 96) begin
      send_cmd(CMD_UNITE, $urandom, $urandom_range(0, TOP), $urandom_range(0, TOP),
               rand61(), rand61(), $urandom_range(0, TOP));
    end else begin
      send_cmd($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI), $urandom, $urandom_range(0, TOP),
               $urandom_range(0, TOP), rand61(), rand61(), $urandom_range(0, TOP));
    end
  endtask

  initial begin
    logic [HW-1:0] b;
    str_len = 0;
    burst_left = 0;
    bases_used = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // directed, reset base
    send_cmd(CMD_LCP, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_LCP, 0, 1, 0, 0, 0, 0);
    send_cmd(CMD_SUB, 0, 0, 0, 0, 0, 0);
    add_sym(8'd0);
    add_sym(8'd255);
    add_sym(8'd96);
    add_sym(8'd95);
    add_sym(8'd97);
    add_sym(8'd128);
    add_sym(8'd97);
    add_sym(8'd255);
    send_cmd(CMD_SUB, 0, 0, 8, 0, 0, 0);
    send_cmd(CMD_SUB, 0, 3, 5, 0, 0, 0);
    send_cmd(CMD_SUB, 0, 5, 3, 0, 0, 0);
    send_cmd(CMD_SUB, 0, 0, 9, 0, 0, 0);
    send_cmd(CMD_LCP, 0, 2, 0, 0, 0, 0);
    send_cmd(CMD_LCP, 0, 8, 0, 0, 0, 0);
    send_cmd(CMD_LCP, 0, 9, 0, 0, 0, 0);
    send_cmd(CMD_UNITE, 0, 0, 0, HMOD, HMOD, 0);
    send_cmd(CMD_UNITE, 0, 0, 0, HMOD - 1, 0, TOP);
    send_cmd(CMD_UNITE, 0, 0, 0, 1, 1, TOP + 1);
    for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
      send_cmd(c, 8'hff, TOP, TOP, HMOD, HMOD, TOP);
    drain();

    // new base without clear keeps the old powers until the next clear
    write_base(61'd2);
    add_sym(8'd98);
    send_cmd(CMD_SUB, 0, 0, str_len, 0, 0, 0);
    send_cmd(CMD_UNITE, 0, 0, 0, 5, 7, 3);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      drain();
      case (ph % 4)
        0: b = 61'd2;
        1: b = HMOD - 1;
        default: begin
          b = rand61();
          if (b < 2 || b >= HMOD) b = 61'd12345;
        end
      endcase
      write_base(b);
      if (ph % 3 != 2) send_cmd(CMD_CLEAR, $urandom, 0, 0, 0, 0, 0);
      period = $urandom_range(1, 16);
      foreach (pattern[i]) pattern[i] = ($urandom_range(0, 1) == 0) ? 8'd97 : $urandom;
      if (ph == 5) begin
        hold_req <= hold_req + 1;
        repeat (12) send_cmd(CMD_UNITE, 0, 0, 0, rand61(), rand61(), $urandom_range(0, TOP));
      end
      repeat (100) random_item();
    end

    drain();
    repeat (200) @(posedge clk);

    $display("commands: %0d clear, %0d append, %0d substring, %0d lcp, %0d unite, %0d reserved",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    $display("base register written %0d times, with bursts, output stalls and a long hold-off",
             bases_used);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== substring_rolling_hash_engine.f =====
rtl/srh_pkg.sv
rtl/srh_mulmod.sv
rtl/srh_dp.sv
rtl/srh_ctrl.sv
rtl/substring_rolling_hash_engine.sv
tb/srh_checker.sv
tb/substring_rolling_hash_engine_tb.sv
